>>> design/cfc_pkg.sv
// ----------------------------------------------------------------------------
// cfc_pkg: shared types and constants for the command frame checker
// Frame marker bytes, configuration indexes, verdict codes and the result
// record that the parser hands to the output stage.
// ----------------------------------------------------------------------------
package cfc_pkg;

	// frame marker bytes
	localparam logic [7:0] START_BYTE = 8'hF7;
	localparam logic [7:0] END_BYTE   = 8'h7F;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_SENDER = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_STATION     = 1'd1;

	// verdict codes
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_CRC    = 3'd1;
	localparam logic [2:0] ST_SENDER = 3'd2;
	localparam logic [2:0] ST_DEST   = 3'd3;
	localparam logic [2:0] ST_TERM   = 3'd4;
	localparam logic [2:0] ST_SHORT  = 3'd5;

	// one result per accepted byte
	typedef struct packed {
		logic       payload_valid;
		logic       payload_is_param;
		logic [7:0] payload_byte;
		logic       status_valid;
		logic [2:0] status;
		logic [7:0] repeat_count;
	} cfc_result_t;

endpackage

>>> design/cfc_parser.sv
// ----------------------------------------------------------------------------
// cfc_parser: frame state machine
// Holds the per-buffer frame state and forms the result for the byte at the
// input in one pass of logic; the state advances when the byte is taken.
// ----------------------------------------------------------------------------
module cfc_parser
	import cfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [7:0]  data_byte,
	input  logic        buffer_end,
	input  logic [7:0]  expected_sender,
	input  logic [7:0]  own_station,
	output cfc_result_t result
);

	localparam logic [3:0] PH_HUNT   = 4'd0;
	localparam logic [3:0] PH_SENDER = 4'd1;
	localparam logic [3:0] PH_DEST   = 4'd2;
	localparam logic [3:0] PH_REPEAT = 4'd3;
	localparam logic [3:0] PH_CMDLEN = 4'd4;
	localparam logic [3:0] PH_PARLEN = 4'd5;
	localparam logic [3:0] PH_CMD    = 4'd6;
	localparam logic [3:0] PH_PARAM  = 4'd7;
	localparam logic [3:0] PH_CRC    = 4'd8;
	localparam logic [3:0] PH_TERM   = 4'd9;
	localparam logic [3:0] PH_DONE   = 4'd10;

	logic [3:0] phase_q, phase_d;
	logic [7:0] cmd_len_q, cmd_len_d;
	logic [7:0] par_len_q, par_len_d;
	logic [7:0] cmd_idx_q, cmd_idx_d;
	logic [7:0] par_idx_q, par_idx_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] rep_q, rep_d;
	logic [7:0] sum_add;
	cfc_result_t res;

	assign sum_add = sum_q + data_byte;

	// next state and result for the byte at the input
	always_comb begin
		phase_d   = phase_q;
		cmd_len_d = cmd_len_q;
		par_len_d = par_len_q;
		cmd_idx_d = cmd_idx_q;
		par_idx_d = par_idx_q;
		sum_d     = sum_q;
		rep_d     = rep_q;
		res       = '0;

		unique case (phase_q)
			PH_HUNT: begin
				if (data_byte == START_BYTE) phase_d = PH_SENDER;
			end
			PH_SENDER: begin
				if (data_byte == expected_sender) begin
					sum_d   = sum_add;
					phase_d = PH_DEST;
				end else begin
					res.status_valid = 1'b1;
					res.status       = ST_SENDER;
					phase_d          = PH_DONE;
				end
			end
			PH_DEST: begin
				if (data_byte == own_station) begin
					sum_d   = sum_add;
					phase_d = PH_REPEAT;
				end else begin
					res.status_valid = 1'b1;
					res.status       = ST_DEST;
					phase_d          = PH_DONE;
				end
			end
			PH_REPEAT: begin
				rep_d   = data_byte;
				sum_d   = sum_add;
				phase_d = PH_CMDLEN;
			end
			PH_CMDLEN: begin
				cmd_len_d = data_byte;
				sum_d     = sum_add;
				phase_d   = PH_PARLEN;
			end
			PH_PARLEN: begin
				par_len_d = data_byte;
				sum_d     = sum_add;
				// empty parts are skipped
				if (cmd_len_q != 8'd0)       phase_d = PH_CMD;
				else if (data_byte != 8'd0)  phase_d = PH_PARAM;
				else                         phase_d = PH_CRC;
			end
			PH_CMD: begin
				res.payload_valid = 1'b1;
				res.payload_byte  = data_byte;
				sum_d             = sum_add;
				cmd_idx_d         = cmd_idx_q + 8'd1;
				if (cmd_idx_d >= cmd_len_q)
					phase_d = (par_len_q != 8'd0) ? PH_PARAM : PH_CRC;
			end
			PH_PARAM: begin
				res.payload_valid    = 1'b1;
				res.payload_is_param = 1'b1;
				res.payload_byte     = data_byte;
				sum_d                = sum_add;
				par_idx_d            = par_idx_q + 8'd1;
				if (par_idx_d >= par_len_q) phase_d = PH_CRC;
			end
			PH_CRC: begin
				if (data_byte == sum_q) begin
					phase_d = PH_TERM;
				end else begin
					res.status_valid = 1'b1;
					res.status       = ST_CRC;
					phase_d          = PH_DONE;
				end
			end
			PH_TERM: begin
				res.status_valid = 1'b1;
				res.status       = (data_byte == END_BYTE) ? ST_OK : ST_TERM;
				phase_d          = PH_DONE;
			end
			default: begin
				// verdict given: ignore bytes up to buffer end
			end
		endcase

		// buffer ended before any verdict
		if (buffer_end && phase_d != PH_DONE && !res.status_valid) begin
			res.status_valid = 1'b1;
			res.status       = ST_SHORT;
		end

		res.repeat_count = rep_d;

		// buffer end: start over for the next buffer
		if (buffer_end) begin
			phase_d   = PH_HUNT;
			cmd_len_d = '0;
			par_len_d = '0;
			cmd_idx_d = '0;
			par_idx_d = '0;
			sum_d     = '0;
			rep_d     = '0;
		end
	end

	assign result = res;

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			cmd_len_q <= '0;
			par_len_q <= '0;
			cmd_idx_q <= '0;
			par_idx_q <= '0;
			sum_q     <= '0;
			rep_q     <= '0;
		end else if (take) begin
			phase_q   <= phase_d;
			cmd_len_q <= cmd_len_d;
			par_len_q <= par_len_d;
			cmd_idx_q <= cmd_idx_d;
			par_idx_q <= par_idx_d;
			sum_q     <= sum_d;
			rep_q     <= rep_d;
		end
	end

endmodule

>>> design/cfc_out_reg.sv
// ----------------------------------------------------------------------------
// cfc_out_reg: result register
// Holds one result until the consumer takes it; refills in the same cycle
// the held result leaves, so a byte can be taken every cycle while the consumer keeps taking results.
// ----------------------------------------------------------------------------
module cfc_out_reg
	import cfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  cfc_result_t load_data,
	output logic        space,
	output logic        out_valid,
	input  logic        out_ready,
	output cfc_result_t out_data
);

	logic        valid_q;
	cfc_result_t data_q;

	assign space     = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

endmodule

>>> design/command_frame_checker.sv
// ----------------------------------------------------------------------------
// command_frame_checker: framed command checker, one byte per request
// Hunts for the start byte, checks sender, destination, CRC and terminator,
// streams out command and parameter bytes and gives one verdict per buffer.
//
//   channel  direction  handshake             content
//   in       input      in_valid / in_ready   data_byte, buffer_end
//   out      output     out_valid / out_ready payload, status, repeat_count
//   cfg      input      cfg_we                cfg_index, cfg_data
//
// One request is taken per cycle while the output is not stalled; its result
// is in the output register on the next cycle. The frame state is updated
// in the same cycle the request is taken, so the next byte sees the new state.
// Reset clears the frame state, the configuration registers and the output valid.
// A stalled output holds in_ready low only while its held result stays.
// ----------------------------------------------------------------------------
module command_frame_checker
	import cfc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           data_byte,
	input  logic                 buffer_end,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 payload_valid,
	output logic                 payload_is_param,
	output logic [7:0]           payload_byte,
	output logic                 status_valid,
	output logic [2:0]           status,
	output logic [7:0]           repeat_count,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	logic [7:0]  sender_q;
	logic [7:0]  station_q;
	logic        take;
	logic        space;
	cfc_result_t next_res;
	cfc_result_t out_res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sender_q  <= '0;
			station_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_EXPECTED_SENDER: sender_q  <= cfg_data;
				CFG_OWN_STATION:     station_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = space;
	assign take     = in_valid && space;

	cfc_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.take            (take),
		.data_byte       (data_byte),
		.buffer_end      (buffer_end),
		.expected_sender (sender_q),
		.own_station     (station_q),
		.result          (next_res)
	);

	cfc_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.load_data (next_res),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_res)
	);

	assign payload_valid    = out_res.payload_valid;
	assign payload_is_param = out_res.payload_is_param;
	assign payload_byte     = out_res.payload_byte;
	assign status_valid     = out_res.status_valid;
	assign status           = out_res.status;
	assign repeat_count     = out_res.repeat_count;

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for command_frame_checker
// Feeds received buffers one byte per request and predicts the payload
// stream and the verdict of every buffer. Each result is checked field by
// field. A short table of hand-made buffers runs first: no start byte, bad
// sender, bad destination, bad terminator, bad CRC. Random buffers follow
// under several station settings and idle patterns. Most are well-formed
// frames with random content; the rest are cut short, corrupted or noise.
// ----------------------------------------------------------------------------
module tb;
	import cfc_pkg::*;

	localparam int CYCLE_LIMIT = 400_000;
	localparam int PHASES = 5;
	localparam int ITEMS_PER_PHASE = 380;
	localparam int DIRECTED_ROWS = 24;

	typedef enum logic [3:0] {
		P_HUNT, P_SENDER, P_DEST, P_REPEAT, P_CMDLEN, P_PARLEN,
		P_CMD, P_PARAM, P_CRC, P_TERM, P_DONE
	} parse_phase_t;

	typedef struct {
		logic [7:0]  data;
		logic        last;
		bit          typed;
		cfc_result_t res;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [7:0]           data_byte = 8'h00;
	logic                 buffer_end = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 payload_valid;
	logic                 payload_is_param;
	logic [7:0]           payload_byte;
	logic                 status_valid;
	logic [2:0]           status;
	logic [7:0]           repeat_count;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_data = 8'h00;

	// frame parser mirror
	parse_phase_t ph = P_HUNT;
	logic [7:0]   cmd_len = 8'h00;
	logic [7:0]   par_len = 8'h00;
	logic [7:0]   cmd_idx = 8'h00;
	logic [7:0]   par_idx = 8'h00;
	logic [7:0]   sum = 8'h00;
	logic [7:0]   rep_cnt = 8'h00;
	logic [7:0]   cfg_sender = 8'h00;
	logic [7:0]   cfg_own = 8'h00;

	cfc_result_t frame_results_q[$];
	logic [7:0]  frame_bytes[$];
	dir_row_t    dir_rows[DIRECTED_ROWS];

	int idle_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int cycle_count = 0;
	int bytes_sent = 0;
	int buffers_sent = 0;
	int payload_seen = 0;
	int verdict_count[6] = '{default: 0};

	command_frame_checker u_top (.*);

	always #2 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("[command_frame_checker] ERROR");
			$finish;
		end
	end

	// receiver backpressure
	always @(negedge clk)
		out_ready = ($urandom_range(0, 99) >= stall_pct);

	// predicted result of one byte; advances the parser mirror
	function automatic cfc_result_t parse_frame_byte(logic [7:0] b, logic last);
		cfc_result_t r;
		r = '0;
		case (ph)
			P_HUNT: if (b == START_BYTE) ph = P_SENDER;
			P_SENDER: begin
				if (b == cfg_sender) begin
					sum += b;
					ph = P_DEST;
				end else begin
					r.status_valid = 1'b1;
					r.status = ST_SENDER;
					ph = P_DONE;
				end
			end
			P_DEST: begin
				if (b == cfg_own) begin
					sum += b;
					ph = P_REPEAT;
				end else begin
					r.status_valid = 1'b1;
					r.status = ST_DEST;
					ph = P_DONE;
				end
			end
			P_REPEAT: begin
				rep_cnt = b;
				sum += b;
				ph = P_CMDLEN;
			end
			P_CMDLEN: begin
				cmd_len = b;
				sum += b;
				ph = P_PARLEN;
			end
			P_PARLEN: begin
				par_len = b;
				sum += b;
				// empty parts are skipped
				if (cmd_len != 0) ph = P_CMD;
				else if (par_len != 0) ph = P_PARAM;
				else ph = P_CRC;
			end
			P_CMD: begin
				r.payload_valid = 1'b1;
				r.payload_byte = b;
				sum += b;
				cmd_idx++;
				if (cmd_idx >= cmd_len) ph = (par_len != 0) ? P_PARAM : P_CRC;
			end
			P_PARAM: begin
				r.payload_valid = 1'b1;
				r.payload_is_param = 1'b1;
				r.payload_byte = b;
				sum += b;
				par_idx++;
				if (par_idx >= par_len) ph = P_CRC;
			end
			P_CRC: begin
				if (b == sum) begin
					ph = P_TERM;
				end else begin
					r.status_valid = 1'b1;
					r.status = ST_CRC;
					ph = P_DONE;
				end
			end
			P_TERM: begin
				r.status_valid = 1'b1;
				r.status = (b == END_BYTE) ? ST_OK : ST_TERM;
				ph = P_DONE;
			end
			default: ;
		endcase
		// buffer ran out before a verdict
		if (last && ph != P_DONE && !r.status_valid) begin
			r.status_valid = 1'b1;
			r.status = ST_SHORT;
		end
		r.repeat_count = rep_cnt;
		if (last) begin
			ph = P_HUNT;
			cmd_len = 8'h00;
			par_len = 8'h00;
			cmd_idx = 8'h00;
			par_idx = 8'h00;
			sum = 8'h00;
			rep_cnt = 8'h00;
		end
		return r;
	endfunction

	function automatic cfc_result_t verdict(logic [2:0] code, logic [7:0] rc);
		cfc_result_t r;
		r = '0;
		r.status_valid = 1'b1;
		r.status = code;
		r.repeat_count = rc;
		return r;
	endfunction

	// mostly short parts, now and then a long one
	function automatic logic [7:0] pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 2) return 8'($urandom_range(200, 255));
		if (r < 14) return 8'($urandom_range(0, 40));
		return 8'($urandom_range(0, 6));
	endfunction

	// one request: random gap, then hold until taken
	task automatic send_byte(logic [7:0] b, logic last, bit typed, cfc_result_t typed_res);
		cfc_result_t r;
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		data_byte = b;
		buffer_end = last;
		do @(posedge clk); while (in_ready !== 1'b1);
		r = parse_frame_byte(b, last);
		if (typed) r = typed_res;
		frame_results_q.push_back(r);
		bytes_sent++;
		if (last) buffers_sent++;
		if (r.payload_valid) payload_seen++;
		if (r.status_valid && r.status <= ST_SHORT) verdict_count[r.status]++;
	endtask

	// drop valid and wait until every result is back
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (frame_results_q.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == CFG_EXPECTED_SENDER) cfg_sender = val;
		else cfg_own = val;
	endtask

	// a well-formed frame with random content, each field sometimes broken
	task automatic append_frame();
		logic [7:0] v, crc, cl, pl;
		int n;
		n = $urandom_range(0, 2);
		repeat (n) begin
			v = 8'($urandom);
			if (v == START_BYTE) v = ~v;
			frame_bytes.push_back(v);
		end
		frame_bytes.push_back(START_BYTE);
		v = ($urandom_range(0, 9) != 0) ? cfg_sender : 8'($urandom);
		frame_bytes.push_back(v);
		crc = v;
		v = ($urandom_range(0, 9) != 0) ? cfg_own : 8'($urandom);
		frame_bytes.push_back(v);
		crc += v;
		v = 8'($urandom);
		frame_bytes.push_back(v);
		crc += v;
		cl = pick_len();
		pl = pick_len();
		frame_bytes.push_back(cl);
		frame_bytes.push_back(pl);
		crc += cl + pl;
		repeat (int'(cl) + int'(pl)) begin
			v = 8'($urandom);
			frame_bytes.push_back(v);
			crc += v;
		end
		if ($urandom_range(0, 9) == 0) crc += 8'($urandom_range(1, 255));
		frame_bytes.push_back(crc);
		frame_bytes.push_back(($urandom_range(0, 9) != 0) ? END_BYTE : 8'($urandom));
		n = $urandom_range(0, 2);
		repeat (n) frame_bytes.push_back(8'($urandom));
	endtask

	// next random buffer: frame, truncated frame or noise
	task automatic build_buffer();
		int kind, n;
		frame_bytes.delete();
		kind = $urandom_range(0, 99);
		if (kind < 85) begin
			append_frame();
			if (kind >= 70) begin
				n = $urandom_range(1, frame_bytes.size() - 1);
				while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
			end
		end else begin
			n = $urandom_range(1, 12);
			repeat (n)
				frame_bytes.push_back(($urandom_range(0, 9) == 0) ? START_BYTE : 8'($urandom));
		end
	endtask

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// result checker
	always @(posedge clk) begin
		cfc_result_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (frame_results_q.size() == 0) begin
				$error("result with no request pending");
				mismatches++;
			end else begin
				want = frame_results_q.pop_front();
				check_field("payload_valid", 8'(want.payload_valid), 8'(payload_valid));
				check_field("payload_is_param", 8'(want.payload_is_param),
					8'(payload_is_param));
				check_field("payload_byte", want.payload_byte, payload_byte);
				check_field("status_valid", 8'(want.status_valid), 8'(status_valid));
				check_field("status", 8'(want.status), 8'(status));
				check_field("repeat_count", want.repeat_count, repeat_count);
			end
		end
	end

	// stimulus
	initial begin
		logic [7:0] sender_tab[PHASES];
		logic [7:0] own_tab[PHASES];
		int idle_tab[PHASES];
		int stall_tab[PHASES];
		int phase_items;
		int nbuf;

		sender_tab = '{8'hA5, 8'h00, 8'hFF, 8'hF7, 8'($urandom)};
		own_tab    = '{8'h3C, 8'hFF, 8'h00, 8'h7F, 8'($urandom)};
		idle_tab   = '{0, 79, 0, 33, 0};
		stall_tab  = '{0, 0, 79, 33, 0};

		// sender A5, station 3C for these rows
		dir_rows = '{
			'{8'h00, 1'b1, 1'b1, verdict(ST_SHORT, 8'h00)},  // no start byte
			'{8'hF7, 1'b0, 1'b0, '0},
			'{8'h00, 1'b0, 1'b1, verdict(ST_SENDER, 8'h00)},
			'{8'hFF, 1'b1, 1'b1, '0},                        // ignored after verdict
			'{8'hF7, 1'b0, 1'b0, '0},
			'{8'hA5, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b1, 1'b1, verdict(ST_DEST, 8'h00)},
			'{8'hF7, 1'b0, 1'b0, '0},
			'{8'hA5, 1'b0, 1'b0, '0},
			'{8'h3C, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b0, 1'b0, '0},                        // repeat count
			'{8'h01, 1'b0, 1'b0, '0},
			'{8'h01, 1'b0, 1'b0, '0},
			'{8'h00, 1'b0, 1'b0, '0},                        // command byte
			'{8'hFF, 1'b0, 1'b0, '0},                        // parameter byte
			'{8'hE1, 1'b0, 1'b0, '0},                        // good CRC
			'{8'h00, 1'b1, 1'b1, verdict(ST_TERM, 8'hFF)},
			'{8'hF7, 1'b0, 1'b0, '0},
			'{8'hA5, 1'b0, 1'b0, '0},
			'{8'h3C, 1'b0, 1'b0, '0},
			'{8'h00, 1'b0, 1'b0, '0},
			'{8'h00, 1'b0, 1'b0, '0},                        // both lengths zero
			'{8'h00, 1'b0, 1'b0, '0},
			'{8'h00, 1'b1, 1'b1, verdict(ST_CRC, 8'h00)}
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int p = 0; p < PHASES; p++) begin
			if (p != 0) drain();
			idle_pct = idle_tab[p];
			stall_pct = stall_tab[p];
			cfg_write(CFG_EXPECTED_SENDER, sender_tab[p]);
			cfg_write(CFG_OWN_STATION, own_tab[p]);
			phase_items = 0;
			nbuf = 0;
			if (p == 0) begin
				foreach (dir_rows[i])
					send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed,
						dir_rows[i].res);
			end
			while (phase_items < ITEMS_PER_PHASE) begin
				build_buffer();
				foreach (frame_bytes[i])
					send_byte(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, '0);
				phase_items += frame_bytes.size();
				nbuf++;
				// hold off until the block has returned everything
				if (nbuf % 9 == 4) drain();
			end
		end

		drain();
		repeat (4) @(posedge clk);
		$display("sent %0d bytes in %0d buffers, %0d payload bytes, %0d station settings",
			bytes_sent, buffers_sent, payload_seen, PHASES);
		$display("verdicts ok %0d, crc %0d, sender %0d, dest %0d, term %0d, short %0d",
			verdict_count[ST_OK], verdict_count[ST_CRC], verdict_count[ST_SENDER],
			verdict_count[ST_DEST], verdict_count[ST_TERM], verdict_count[ST_SHORT]);
		if (mismatches == 0) begin
			$display("[command_frame_checker] OK");
		end else begin
			$display("[command_frame_checker] ERROR");
		end
		$finish;
	end

endmodule
